### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cons holds in the same cycle whenever ante holds.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/core/srre_pkg.sv
// ----------------------------------------------------------------------------
// srre_pkg
// Types and constants of the scanline run rectangle extractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srre_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CfgRowWidth   = 2'd0,
    CfgScale      = 2'd1,
    CfgBackground = 2'd2
  } cfg_reg_e;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 16;

  localparam logic [12:0] RowWidthReset   = 13'd64;
  localparam logic [15:0] ScaleReset      = 16'd1000;
  localparam logic [7:0]  BackgroundReset = 8'd255;

  localparam int unsigned CoordWidth = 28;
  localparam int unsigned YEndWidth  = 29;

  // Unscaled rectangle, sized for the largest supported image
  typedef struct packed {
    logic [7:0]  idx;
    logic [15:0] xs;
    logic [16:0] xe;
    logic [15:0] row;
    logic        last;
  } rect_t;

endpackage

### rtl/core/scanline_run_rectangle_extractor_core.sv
// ----------------------------------------------------------------------------
// scanline_run_rectangle_extractor_core
// Cuts raster rows of palette pixels into runs and emits scaled rectangles.
//
// Input channel: one pixel per transaction (pixel_index_i, frame_start_i),
// bottom row first. frame_start_i clears column, row and run state so the
// pixel becomes column 0 of row 0. Output channel: one rectangle per
// transaction; last_of_step_o marks the final rectangle of a pixel.
// A pixel's rectangles go into the queue, then the output register. Throughput
// is one pixel per cycle while in_stall_o is low. A pixel yields at most two
// rectangles; a four-entry queue of unscaled rectangles sits between the run
// tracker and the multiply stage, and in_stall_o rises while fewer than two
// entries are free. The output register drains one rectangle per cycle while
// out_stall_i is low, so a long output stall fills the queue and then holds
// the input. Configuration is written through cfg_we_i / cfg_index_i /
// cfg_data_i while the block is idle; the user must keep to this, as the
// block does not enforce it. Reset clears all counters and run state and
// restores row width 64, scale 1000, background index 255; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scanline_run_rectangle_extractor_core #(
  parameter int unsigned MAX_WIDTH = 4096,
  parameter int unsigned MAX_ROWS  = 4096
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration
  input  logic                                  cfg_we_i,
  input  logic [srre_pkg::CfgIndexWidth-1:0]    cfg_index_i,
  input  logic [srre_pkg::CfgDataWidth-1:0]     cfg_data_i,
  // pixel input
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [7:0]                            pixel_index_i,
  input  logic                                  frame_start_i,
  // rectangle output
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [7:0]                            run_index_o,
  output logic [srre_pkg::CoordWidth-1:0]       x_start_o,
  output logic [srre_pkg::CoordWidth-1:0]       y_start_o,
  output logic [srre_pkg::CoordWidth-1:0]       x_end_o,
  output logic [srre_pkg::YEndWidth-1:0]        y_end_o,
  output logic                                  last_of_step_o
);

  import srre_pkg::*;

  // Column and row counters are as narrow as the image limits allow.
  localparam int unsigned ColWidth  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RowWidth  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam logic [16:0] MaxWidth  = 17'(MAX_WIDTH);
  localparam logic [16:0] MaxRows   = 17'(MAX_ROWS);
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QPtrWidth = $clog2(QDepth);
  localparam int unsigned QCntWidth = $clog2(QDepth + 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [12:0] row_width_q;
  logic [15:0] scale_q;
  logic [7:0]  background_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q  <= RowWidthReset;
      scale_q      <= ScaleReset;
      background_q <= BackgroundReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgRowWidth:   row_width_q  <= cfg_data_i[12:0];
        CfgScale:      scale_q      <= cfg_data_i;
        CfgBackground: background_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Run tracker state
  // ---------------------------------------------------------------------------
  logic [ColWidth-1:0] col_q, col_d;
  logic [RowWidth-1:0] row_q, row_d;
  logic [7:0]          run_val_q, run_val_d;
  logic [ColWidth-1:0] run_start_q, run_start_d;
  logic                in_run_q, in_run_d;
  logic                started_q, started_d;

  logic                in_accept;
  logic [16:0]         width_eff;
  logic [ColWidth-1:0] col_cur;
  logic [RowWidth-1:0] row_cur;
  logic                in_run_cur;
  logic                started_cur;
  logic [16:0]         col_next;
  logic                row_end;
  logic                emit_a;
  logic                emit_b;
  rect_t               rect_a;
  rect_t               rect_b;

  assign in_accept = in_valid_i && !in_stall_o;

  always_comb begin
    // Clamp the row width into 1 .. MAX_WIDTH.
    if (row_width_q == 13'd0) begin
      width_eff = 17'd1;
    end else if (17'(row_width_q) > MaxWidth) begin
      width_eff = MaxWidth;
    end else begin
      width_eff = 17'(row_width_q);
    end

    // Frame start clears counters before this pixel is taken.
    col_cur     = frame_start_i ? '0 : col_q;
    row_cur     = frame_start_i ? '0 : row_q;
    in_run_cur  = frame_start_i ? 1'b0 : in_run_q;
    started_cur = frame_start_i ? 1'b0 : started_q;

    col_next = 17'(col_cur) + 17'd1;
    row_end  = (col_next >= width_eff);

    run_val_d   = run_val_q;
    run_start_d = run_start_q;
    in_run_d    = in_run_cur;
    started_d   = started_cur;
    emit_a      = 1'b0;

    if (!started_cur) begin
      // Skip leading background; the first other pixel opens a run.
      if (pixel_index_i != background_q) begin
        started_d   = 1'b1;
        in_run_d    = 1'b1;
        run_start_d = col_cur;
        run_val_d   = pixel_index_i;
      end
    end else begin
      if (pixel_index_i != run_val_q) begin
        emit_a      = (run_val_q != background_q);
        run_start_d = col_cur;
        in_run_d    = (pixel_index_i != background_q);
      end
      run_val_d = pixel_index_i;
    end

    rect_a.idx  = run_val_q;
    rect_a.xs   = 16'(run_start_q);
    rect_a.xe   = 17'(col_cur);
    rect_a.row  = 16'(row_cur);
    rect_a.last = 1'b0;

    // Row end closes the open run and resets run state.
    emit_b      = row_end && in_run_d;
    rect_b.idx  = run_val_d;
    rect_b.xs   = 16'(run_start_d);
    rect_b.xe   = col_next;
    rect_b.row  = 16'(row_cur);
    rect_b.last = 1'b1;
    if (!emit_b) begin
      rect_a.last = 1'b1;
    end

    if (row_end) begin
      in_run_d  = 1'b0;
      started_d = 1'b0;
      col_d     = '0;
      if (17'(row_cur) + 17'd1 >= MaxRows) begin
        row_d = '0;
      end else begin
        row_d = row_cur + RowWidth'(1);
      end
    end else begin
      col_d = col_next[ColWidth-1:0];
      row_d = row_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      run_val_q   <= '0;
      run_start_q <= '0;
      in_run_q    <= 1'b0;
      started_q   <= 1'b0;
    end else if (in_accept) begin
      col_q       <= col_d;
      row_q       <= row_d;
      run_val_q   <= run_val_d;
      run_start_q <= run_start_d;
      in_run_q    <= in_run_d;
      started_q   <= started_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Rectangle queue: takes up to two entries per pixel; unless the output stalls, drains one per cycle
  // ---------------------------------------------------------------------------
  rect_t                queue_q [QDepth];
  logic [QPtrWidth-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntWidth-1:0] cnt_q, cnt_d;
  logic [1:0]           push_n;
  rect_t                push_first;
  logic                 pop;
  rect_t                head;

  assign push_first = emit_a ? rect_a : rect_b;
  assign push_n     = in_accept ? (2'(emit_a) + 2'(emit_b)) : 2'd0;
  assign head       = queue_q[rd_ptr_q];
  assign pop        = (cnt_q != '0) && (!out_valid_o || !out_stall_i);
  assign cnt_d      = cnt_q + QCntWidth'(push_n) - QCntWidth'(pop);

  // Hold the input while fewer than two entries are free.
  assign in_stall_o = (cnt_q > QCntWidth'(QDepth - 2));

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      queue_q[wr_ptr_q] <= push_first;
    end
    if (push_n == 2'd2) begin
      queue_q[wr_ptr_q + QPtrWidth'(1)] <= rect_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPtrWidth'(push_n);
      rd_ptr_q <= rd_ptr_q + QPtrWidth'(pop);
      cnt_q    <= cnt_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Scale stage: four products of up to 17x16 bits into the output register
  // ---------------------------------------------------------------------------
  logic [32:0] xs_prod, ys_prod, xe_prod, ye_prod;
  logic        out_valid_q;

  assign xs_prod = 33'(head.xs) * 33'(scale_q);
  assign ys_prod = 33'(head.row) * 33'(scale_q);
  assign xe_prod = 33'(head.xe) * 33'(scale_q);
  assign ye_prod = (33'(head.row) + 33'd1) * 33'(scale_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= pop;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      run_index_o    <= head.idx;
      x_start_o      <= xs_prod[CoordWidth-1:0];
      y_start_o      <= ys_prod[CoordWidth-1:0];
      x_end_o        <= xe_prod[CoordWidth-1:0];
      y_end_o        <= ye_prod[YEndWidth-1:0];
      last_of_step_o <= head.last;
    end
  end

  assign out_valid_o = out_valid_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ASSERT_ALWAYS(a_queue_bound, clk_i, rst_ni, cnt_q <= QCntWidth'(QDepth),
                 "rectangle queue overflow")
  `ASSERT_IMPLIES(a_push_room, clk_i, rst_ni, push_n != 2'd0,
                  cnt_q <= QCntWidth'(QDepth - 2), "push without room for two")
  `ASSERT_IMPLIES(a_last_closes, clk_i, rst_ni, push_n == 2'd2,
                  !rect_a.last && rect_b.last, "two rectangles with bad last flags")

endmodule
